/* hdl/ccst_pkg.sv */
// Package for the compacting code set table.
// Holds the operation codes, field widths and sequencer state type.
// No dependencies; ccst_if and the top level use it.
`default_nettype none

package ccst_pkg;

  localparam int unsigned CODE_W = 16;
  localparam int unsigned OP_W   = 2;

  typedef logic [CODE_W-1:0] code_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

/* hdl/ccst_if.sv */
// Valid/ready channel interfaces of the compacting code set table.
// ccst_req_if carries operation requests, ccst_rsp_if carries results.
// Depends on ccst_pkg.
`default_nettype none

interface ccst_req_if;
  logic               valid;
  logic               ready;
  ccst_pkg::op_t      operation;
  ccst_pkg::code_t    item_code;

  modport source (output valid, output operation, output item_code, input ready);
  modport sink   (input valid, input operation, input item_code, output ready);
endinterface

interface ccst_rsp_if;
  logic valid;
  logic ready;
  logic success;

  modport source (output valid, output success, input ready);
  modport sink   (input valid, input success, output ready);
endinterface

`default_nettype wire

/* hdl/ccst_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the slot store of the code set table; no dependencies.
`default_nettype none

module ccst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hdl/compacting_code_set_table.sv */
// Top level of the compacting code set table: sequencer, fill count and output register.
// Depends on ccst_pkg, ccst_if (ccst_req_if, ccst_rsp_if) and ccst_ram.
//
//   Channel  Dir  Payload                          Meaning
//   req      in   operation[1:0], item_code[15:0]  insert, remove, lookup or clear request
//   rsp      out  success                          one result per request
//
// Clear, and any request with code zero, go straight from idle to ST_RESP.
// Otherwise the single comparator walks the occupied slots through the one
// RAM read port, alternating ST_SCAN_RD and ST_SCAN_CMP; an insert that
// matches nothing appends, and a removal shifts each later slot one place
// toward the front through ST_SHIFT_RD and ST_SHIFT_WR. The block takes one
// request at a time.
// Reset is synchronous and clears only the fill count and control; slots at or
// beyond the fill count read as empty, so no clearing pass is needed.
// A result waits in the output register while rsp.ready is low, and the
// request channel is ready again once the result is loaded there.
`default_nettype none

module compacting_code_set_table #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ccst_req_if.sink         req,
  ccst_rsp_if.source       rsp
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

  // Control registers.
  ccst_pkg::state_t state, state_next;
  logic [CNT_W-1:0] fill, fill_next;   // number of occupied slots, packed at the front
  logic [CNT_W-1:0] idx, idx_next;     // scan or shift position
  logic             ok, ok_next;
  logic             out_valid, out_valid_next;

  // Request payload held for the duration of the operation.
  ccst_pkg::op_t    op;
  ccst_pkg::code_t  code;
  logic             out_success;

  // RAM port signals.
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  ccst_pkg::code_t         wr_data;
  logic [IDX_W-1:0]        rd_addr;
  ccst_pkg::code_t         rd_data;

  logic             accept;
  logic             rsp_free;
  logic             scan_done;
  logic             shift_done;
  logic             hit;
  logic             has_room;
  logic [CNT_W-1:0] idx_prev;

  assign accept     = req.valid && req.ready;
  assign rsp_free   = !out_valid || rsp.ready;
  assign scan_done  = (idx == fill);
  assign shift_done = (idx == fill);
  assign hit        = (rd_data == code);
  assign has_room   = (fill != FULL_CNT);
  assign idx_prev   = idx - CNT_W'(1);

  assign req.ready   = (state == ccst_pkg::ST_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.success = out_success;

  ccst_ram #(
    .WIDTH (ccst_pkg::CODE_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ccst_pkg::ST_IDLE: begin
        if (accept) begin
          // Clear and code zero are settled without a scan.
          if (req.operation == ccst_pkg::OP_CLEAR || req.item_code == '0) begin
            state_next = ccst_pkg::ST_RESP;
          end else begin
            state_next = ccst_pkg::ST_SCAN_RD;
          end
        end
      end
      ccst_pkg::ST_SCAN_RD: begin
        state_next = scan_done ? ccst_pkg::ST_RESP : ccst_pkg::ST_SCAN_CMP;
      end
      ccst_pkg::ST_SCAN_CMP: begin
        if (!hit) begin
          state_next = ccst_pkg::ST_SCAN_RD;
        end else if (op == ccst_pkg::OP_REMOVE) begin
          state_next = ccst_pkg::ST_SHIFT_RD;
        end else begin
          state_next = ccst_pkg::ST_RESP;
        end
      end
      ccst_pkg::ST_SHIFT_RD: begin
        state_next = shift_done ? ccst_pkg::ST_RESP : ccst_pkg::ST_SHIFT_WR;
      end
      ccst_pkg::ST_SHIFT_WR: begin
        state_next = ccst_pkg::ST_SHIFT_RD;
      end
      ccst_pkg::ST_RESP: begin
        if (rsp_free) begin
          state_next = ccst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ccst_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control: RAM ports, fill count, scan index and result.
  always_comb begin
    fill_next      = fill;
    idx_next       = idx;
    ok_next        = ok;
    out_valid_next = out_valid && !rsp.ready;
    wr_en          = 1'b0;
    wr_addr        = fill[IDX_W-1:0];
    wr_data        = code;
    rd_addr        = idx[IDX_W-1:0];
    unique case (state)
      ccst_pkg::ST_IDLE: begin
        idx_next = '0;
        if (accept) begin
          if (req.operation == ccst_pkg::OP_CLEAR) begin
            fill_next = '0;
            ok_next   = 1'b1;
          end else begin
            // Code zero matches the first empty slot, which exists unless full.
            ok_next = has_room;
          end
        end
      end
      ccst_pkg::ST_SCAN_RD: begin
        if (scan_done) begin
          // No occupied slot matched: an insert appends if there is room.
          if (op == ccst_pkg::OP_INSERT && has_room) begin
            wr_en     = 1'b1;
            fill_next = fill + CNT_W'(1);
            ok_next   = 1'b1;
          end else begin
            ok_next = 1'b0;
          end
        end
      end
      ccst_pkg::ST_SCAN_CMP: begin
        idx_next = idx + CNT_W'(1);
        if (hit) begin
          ok_next = 1'b1;
        end
      end
      ccst_pkg::ST_SHIFT_RD: begin
        if (shift_done) begin
          fill_next = fill - CNT_W'(1);
        end
      end
      ccst_pkg::ST_SHIFT_WR: begin
        // Move the slot just read one place toward the front.
        wr_en    = 1'b1;
        wr_addr  = idx_prev[IDX_W-1:0];
        wr_data  = rd_data;
        idx_next = idx + CNT_W'(1);
      end
      ccst_pkg::ST_RESP: begin
        if (rsp_free) begin
          out_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccst_pkg::ST_IDLE;
      fill      <= '0;
      idx       <= '0;
      ok        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      idx       <= idx_next;
      ok        <= ok_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= req.operation;
      code <= req.item_code;
    end
    if (state == ccst_pkg::ST_RESP && rsp_free) begin
      out_success <= ok;
    end
  end

endmodule

`default_nettype wire
